@@ hdl/cgp_genome_mutator_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the genome mutator
// ----------------------------------------------------------------------------
`ifndef CGP_GENOME_MUTATOR_TOP_MACROS_SVH
`define CGP_GENOME_MUTATOR_TOP_MACROS_SVH

// Property checked outside reset
`define CGM_ASSERT_RUN(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cgm assertion failed");

// Property checked at every edge, reset included
`define CGM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("cgm assertion failed");

`endif

@@ hdl/cgm_pkg.sv @@
// ----------------------------------------------------------------------------
// cgm_pkg
// Types, constants and the xorshift step shared by the genome mutator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cgm_pkg;

   // Field widths
   localparam int WORD_W    = 32;
   localparam int NODE_W    = 5;
   localparam int TABLE_W   = 16;
   localparam int ROUTE_W   = 20;
   localparam int OMAP_W    = 18;
   localparam int ROUTE_BITS = 5;
   localparam int OUT_BITS  = 6;
   localparam int ROUTE_FIELDS = 4;
   localparam int OUT_FIELDS = 3;
   localparam int RANGE_W   = 6;
   localparam int FIELD_W   = 2;
   localparam int ADDR_W    = 4;

   // Default structure of the genome
   localparam int NODE_COUNT_DEF     = 30;
   localparam int PRIMARY_INPUTS_DEF = 3;
   localparam int OUTPUT_COUNT_DEF   = 3;

   // Register reset values
   localparam logic [WORD_W-1:0] TABLE_THR_RESET = 32'd141733920;
   localparam logic [WORD_W-1:0] ROUTE_THR_RESET = 32'd34359738;
   localparam logic [WORD_W-1:0] SEED_RESET      = 32'h1234_5678;

   // Register indexes
   localparam logic [1:0] REG_TABLE_THR = 2'd0;
   localparam logic [1:0] REG_ROUTE_THR = 2'd1;
   localparam logic [1:0] REG_SEED      = 2'd2;

   // Item kinds
   localparam logic KIND_NODE = 1'b0;
   localparam logic KIND_OUT  = 1'b1;

   typedef struct packed {
      logic               item_kind;
      logic [NODE_W-1:0]  node_index;
      logic [TABLE_W-1:0] truth_table;
      logic [ROUTE_W-1:0] routing_word;
      logic [OMAP_W-1:0]  output_map;
   } cgm_req_type;

   typedef struct packed {
      logic [TABLE_W-1:0] new_truth_table;
      logic [ROUTE_W-1:0] new_routing_word;
      logic [OMAP_W-1:0]  new_output_map;
      logic               changed;
   } cgm_rsp_type;

   // Classified item handed from front to back
   typedef struct packed {
      logic               kind;
      logic [RANGE_W-1:0] range;
      logic [TABLE_W-1:0] truth_table;
      logic [ROUTE_W-1:0] routing_word;
      logic [OMAP_W-1:0]  output_map;
   } cgm_work_type;

   // Control settings from the register file to the back end
   typedef struct packed {
      logic [WORD_W-1:0] table_threshold;
      logic [WORD_W-1:0] route_threshold;
      logic              seed_load;
      logic [WORD_W-1:0] seed_value;
   } cgm_ctrl_type;

   // One xorshift step: x ^= x<<13; x ^= x>>17; x ^= x<<5
   function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      a = x ^ (x << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

endpackage

`default_nettype wire

@@ hdl/cgm_front.sv @@
// ----------------------------------------------------------------------------
// cgm_front
// Accepts request transfers, clamps the node index, forms the source range
// and holds classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cgm_front
   import cgm_pkg::*;
#(
   parameter int NODE_COUNT     = NODE_COUNT_DEF,
   parameter int PRIMARY_INPUTS = PRIMARY_INPUTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire cgm_req_type  req_data,
   output logic              work_valid,
   output cgm_work_type      work_data,
   input  wire logic         work_take
);

   localparam logic [NODE_W-1:0] NODE_MAX = NODE_W'(NODE_COUNT - 1);

   cgm_work_type      entry_ff [2];
   logic [1:0]        count_ff, count_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [NODE_W-1:0] node_clamped;
   cgm_work_type      classified;
   logic              do_push;
   logic              do_pop;

   // Classification: clamp node number, pick the scaling range
   always_comb begin
      node_clamped = (req_data.node_index > NODE_MAX) ? NODE_MAX : req_data.node_index;
      classified.kind = req_data.item_kind;
      if (req_data.item_kind == KIND_OUT) begin
         classified.range = RANGE_W'(NODE_COUNT);
      end else begin
         classified.range = RANGE_W'(PRIMARY_INPUTS) + RANGE_W'(node_clamped);
      end
      classified.truth_table  = req_data.truth_table;
      classified.routing_word = req_data.routing_word;
      classified.output_map   = req_data.output_map;
   end

   assign full       = (count_ff == 2'd2);
   assign work_valid = (count_ff != 2'd0);
   assign work_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = work_take && work_valid;

   // Queue pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

@@ hdl/cgm_back.sv @@
// ----------------------------------------------------------------------------
// cgm_back
// Sequencer that carries out one classified item with one generator draw
// per cycle in its test and load states, and the result register seen by the response side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cgm_back
   import cgm_pkg::*;
#(
   parameter int PRIMARY_INPUTS = PRIMARY_INPUTS_DEF,
   parameter int OUTPUT_COUNT   = OUTPUT_COUNT_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cgm_ctrl_type  ctrl,
   input  wire logic          work_valid,
   input  wire cgm_work_type  work_data,
   output logic               work_take,
   output logic               empty,
   input  wire logic          pop,
   output cgm_rsp_type        rsp_data
);

   localparam int PROD_W = WORD_W + RANGE_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TTEST = 3'd1;
   localparam logic [2:0] S_TLOAD = 3'd2;
   localparam logic [2:0] S_RTEST = 3'd3;
   localparam logic [2:0] S_RLOAD = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [WORD_W-1:0]  gen_ff, gen_in;
   logic [FIELD_W-1:0] field_ff, field_in;
   cgm_work_type       work_ff, work_in;
   logic               changed_ff, changed_in;
   cgm_rsp_type        rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  draw;
   logic [PROD_W-1:0]  prod;
   logic [RANGE_W-1:0] scaled;
   logic [OUT_BITS-1:0] out_src;
   logic               last_field;
   logic               rsp_free;

   // Next draw and source scaling by multiply-high
   always_comb begin
      draw    = xorshift(gen_ff);
      prod    = PROD_W'(draw) * PROD_W'(work_ff.range);
      scaled  = prod[PROD_W-1:WORD_W];
      out_src = OUT_BITS'(scaled) + OUT_BITS'(PRIMARY_INPUTS);
      if (work_ff.kind == KIND_OUT) begin
         last_field = (field_ff == FIELD_W'(OUTPUT_COUNT - 1));
      end else begin
         last_field = (field_ff == FIELD_W'(ROUTE_FIELDS - 1));
      end
   end

   assign rsp_free = !rsp_valid_ff || pop;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      field_in     = field_ff;
      work_in      = work_ff;
      changed_in   = changed_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      work_take    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (work_valid) begin
               work_take  = 1'b1;
               work_in    = work_data;
               field_in   = '0;
               changed_in = 1'b0;
               state_in   = (work_data.kind == KIND_OUT) ? S_RTEST : S_TTEST;
            end
         end
         S_TTEST: begin
            gen_in   = draw;
            state_in = (draw < ctrl.table_threshold) ? S_TLOAD : S_RTEST;
         end
         S_TLOAD: begin
            gen_in               = draw;
            work_in.truth_table  = draw[TABLE_W-1:0];
            changed_in           = 1'b1;
            state_in             = S_RTEST;
         end
         S_RTEST: begin
            gen_in = draw;
            if (draw < ctrl.route_threshold) begin
               state_in = S_RLOAD;
            end else if (last_field) begin
               state_in = S_DONE;
            end else begin
               field_in = field_ff + 1'b1;
            end
         end
         S_RLOAD: begin
            gen_in     = draw;
            changed_in = 1'b1;
            // replace the selected source field
            if (work_ff.kind == KIND_OUT) begin
               for (int l = 0; l < OUT_FIELDS; l++) begin
                  if (field_ff == FIELD_W'(l)) begin
                     work_in.output_map[l*OUT_BITS +: OUT_BITS] = out_src;
                  end
               end
            end else begin
               for (int l = 0; l < ROUTE_FIELDS; l++) begin
                  if (field_ff == FIELD_W'(l)) begin
                     work_in.routing_word[l*ROUTE_BITS +: ROUTE_BITS] =
                        scaled[ROUTE_BITS-1:0];
                  end
               end
            end
            if (last_field) begin
               state_in = S_DONE;
            end else begin
               field_in = field_ff + 1'b1;
               state_in = S_RTEST;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_in.new_truth_table  = work_ff.truth_table;
               rsp_in.new_routing_word = work_ff.routing_word;
               rsp_in.new_output_map   = work_ff.output_map;
               rsp_in.changed          = changed_ff;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // seed write reloads the generator (the user writes it only while idle; the block does not enforce this)
      if (ctrl.seed_load) begin
         gen_in = ctrl.seed_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gen_ff       <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      field_ff   <= field_in;
      work_ff    <= work_in;
      changed_ff <= changed_in;
      rsp_ff     <= rsp_in;
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

@@ hdl/cgp_genome_mutator_top.sv @@
// ----------------------------------------------------------------------------
// cgp_genome_mutator_top
// Point mutation of Cartesian genetic programming gene words.
// ----------------------------------------------------------------------------
// Gene words enter through a queue-style request port and leave as mutated
// words through a queue-style response port, one result per item, in order.
// The back end picks an item up, makes one draw of the single xorshift
// generator per cycle in its test and load steps, one draw per threshold
// test and one more per hit, and hands the item off once the result
// register is free. A two-entry queue in front takes new items while the
// back end works, and a result register holds a finished result until it is
// popped. Writing the seed register reloads the generator; the user must
// write registers only while no item is in flight, which the block does not
// enforce.
`timescale 1ns / 1ps
`default_nettype none

module cgp_genome_mutator_top
   import cgm_pkg::*;
#(
   parameter int NODE_COUNT     = NODE_COUNT_DEF,
   parameter int PRIMARY_INPUTS = PRIMARY_INPUTS_DEF,
   parameter int OUTPUT_COUNT   = OUTPUT_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire cgm_req_type       req_data,
   output logic                   empty,
   input  wire logic              pop,
   output cgm_rsp_type            rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [WORD_W-1:0] pwdata,
   output logic [WORD_W-1:0]      prdata,
   output logic                   pready
);

   logic [WORD_W-1:0] table_thr_ff;
   logic [WORD_W-1:0] route_thr_ff;
   logic [WORD_W-1:0] seed_ff;
   logic [1:0]        reg_index;
   logic              csr_write;
   cgm_ctrl_type      ctrl;
   logic              work_valid;
   logic              work_take;
   cgm_work_type      work_data;

   // Register file
   assign pready    = 1'b1;
   assign reg_index = paddr[ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_thr_ff <= TABLE_THR_RESET;
         route_thr_ff <= ROUTE_THR_RESET;
         seed_ff      <= SEED_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_TABLE_THR: table_thr_ff <= pwdata;
            REG_ROUTE_THR: route_thr_ff <= pwdata;
            REG_SEED:      seed_ff      <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_TABLE_THR: prdata = table_thr_ff;
         REG_ROUTE_THR: prdata = route_thr_ff;
         REG_SEED:      prdata = seed_ff;
         default:       prdata = '0;
      endcase
   end

   always_comb begin
      ctrl.table_threshold = table_thr_ff;
      ctrl.route_threshold = route_thr_ff;
      ctrl.seed_load       = csr_write && (reg_index == REG_SEED);
      ctrl.seed_value      = pwdata;
   end

   cgm_front #(
      .NODE_COUNT     (NODE_COUNT),
      .PRIMARY_INPUTS (PRIMARY_INPUTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_take  (work_take)
   );

   cgm_back #(
      .PRIMARY_INPUTS (PRIMARY_INPUTS),
      .OUTPUT_COUNT   (OUTPUT_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_take  (work_take),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

@@ hdl/cgm_checker.sv @@
// ----------------------------------------------------------------------------
// cgm_checker
// Port-level checks of the genome mutator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cgp_genome_mutator_top_macros.svh"

module cgm_checker
   import cgm_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              full,
   input wire logic              empty,
   input wire logic              pop,
   input wire cgm_rsp_type       rsp_data,
   input wire logic              psel,
   input wire logic              penable,
   input wire logic              pwrite,
   input wire logic [ADDR_W-1:0] paddr,
   input wire logic [WORD_W-1:0] pwdata,
   input wire logic [WORD_W-1:0] prdata
);

   // Reset leaves the result register empty and the request queue not full
   `CGM_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (empty && !full))

   // A waiting result holds until it is popped
   `CGM_ASSERT_RUN(a_rsp_hold, clock, reset,
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))

   // A table threshold write reads back on the next cycle
   `CGM_ASSERT_RUN(a_thr_readback, clock, reset,
      (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_TABLE_THR)) |=>
      ((paddr[ADDR_W-1:2] != REG_TABLE_THR) || (prdata == $past(pwdata))))

endmodule

bind cgp_genome_mutator_top cgm_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data),
   .psel     (psel),
   .penable  (penable),
   .pwrite   (pwrite),
   .paddr    (paddr),
   .pwdata   (pwdata),
   .prdata   (prdata)
);

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CGP genome mutator
// ----------------------------------------------------------------------------
// Gene words go in through the push/full port and mutated words come back
// through the empty/pop port. A local xorshift model predicts every mutated
// word, and each popped result is compared with the oldest prediction. The
// thresholds and the seed are rewritten between phases while the block is
// idle. Both sides insert random gaps.
// ----------------------------------------------------------------------------

module tb_top;
   import cgm_pkg::*;

   localparam int NODES   = NODE_COUNT_DEF;
   localparam int INPUTS  = PRIMARY_INPUTS_DEF;
   localparam int OUTPUTS = OUTPUT_COUNT_DEF;
   localparam int HALF_PERIOD = 6;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 30;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               push = 1'b0;
   logic               full;
   cgm_req_type        req_data = '0;
   logic               empty;
   logic               pop = 1'b0;
   cgm_rsp_type        rsp_data;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [ADDR_W-1:0]  paddr = '0;
   logic [WORD_W-1:0]  pwdata = '0;
   logic [WORD_W-1:0]  prdata;
   logic               pready;

   // Mirror of the block's registers and generator
   logic [WORD_W-1:0] table_thr;
   logic [WORD_W-1:0] route_thr;
   logic [WORD_W-1:0] seed_val;
   logic [WORD_W-1:0] gen_word;

   cgm_req_type pending_genes[$];
   cgm_rsp_type expected_genes[$];

   int errors = 0;
   int cycles = 0;
   int send_gap = 0;
   int send_burst = 0;
   int recv_gap = 0;
   int recv_burst = 0;

   cgp_genome_mutator_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Clock
   always #HALF_PERIOD clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // One xorshift step of the generator copy
   function automatic logic [WORD_W-1:0] next_draw();
      logic [WORD_W-1:0] x;
      x = gen_word;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      gen_word = x;
      return x;
   endfunction

   // Multiply-high scaling of a draw into [0, span)
   function automatic logic [WORD_W-1:0] scaled(logic [WORD_W-1:0] r, int span);
      logic [63:0] prod;
      prod = {32'b0, r} * 64'(span);
      return prod[63:32];
   endfunction

   // Expected child word for one parent word; advances the generator copy
   function automatic cgm_rsp_type mutate_gene(cgm_req_type g);
      cgm_rsp_type r;
      int node;
      logic [WORD_W-1:0] d;
      logic [WORD_W-1:0] src;
      r.new_truth_table  = g.truth_table;
      r.new_routing_word = g.routing_word;
      r.new_output_map   = g.output_map;
      r.changed          = 1'b0;
      if (g.item_kind == KIND_NODE) begin
         node = (int'(g.node_index) > NODES - 1) ? NODES - 1 : int'(g.node_index);
         if (next_draw() < table_thr) begin
            d = next_draw();
            r.new_truth_table = d[TABLE_W-1:0];
            r.changed = 1'b1;
         end
         for (int j = 0; j < ROUTE_FIELDS; j++) begin
            if (next_draw() < route_thr) begin
               src = scaled(next_draw(), INPUTS + node);
               r.new_routing_word[j*ROUTE_BITS +: ROUTE_BITS] = src[ROUTE_BITS-1:0];
               r.changed = 1'b1;
            end
         end
      end else begin
         for (int j = 0; j < OUTPUTS && j < OUT_FIELDS; j++) begin
            if (next_draw() < route_thr) begin
               src = scaled(next_draw(), NODES) + INPUTS;
               r.new_output_map[j*OUT_BITS +: OUT_BITS] = src[OUT_BITS-1:0];
               r.changed = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // Gap length: mostly short, a few long, with stretches of none
   function automatic int gap_len(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Driver: one transfer per accepted push, then a random gap
   always @(posedge clock) begin : drive_req
      logic send;
      if (reset) begin
         push <= 1'b0;
      end else begin
         send = push;
         if (push && !full) begin
            expected_genes.push_back(mutate_gene(req_data));
            void'(pending_genes.pop_front());
            send_gap = gap_len(send_burst);
            send = 1'b0;
         end
         if (!send) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_genes.size() > 0) begin
               send = 1'b1;
               req_data <= pending_genes[0];
            end
         end
         push <= send;
      end
   end

   // Monitor: compare each popped result with the oldest prediction
   always @(posedge clock) begin : watch_rsp
      cgm_rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_genes.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result transfer: %h", rsp_data);
            end else begin
               want = expected_genes.pop_front();
               if (rsp_data.new_truth_table !== want.new_truth_table ||
                   rsp_data.new_routing_word !== want.new_routing_word ||
                   rsp_data.new_output_map !== want.new_output_map ||
                   rsp_data.changed !== want.changed) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: table %h/%h route %h/%h omap %h/%h chg %b/%b",
                              want.new_truth_table, rsp_data.new_truth_table,
                              want.new_routing_word, rsp_data.new_routing_word,
                              want.new_output_map, rsp_data.new_output_map,
                              want.changed, rsp_data.changed);
               end
            end
            recv_gap = gap_len(recv_burst);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Register write: setup then access, and update the mirror
   task automatic write_reg(logic [1:0] idx, logic [WORD_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_TABLE_THR: table_thr = value;
         REG_ROUTE_THR: route_thr = value;
         REG_SEED: begin
            seed_val = value;
            gen_word = value;
         end
         default: ;
      endcase
   endtask

   // Register read with check against the mirror
   task automatic check_reg(logic [1:0] idx, logic [WORD_W-1:0] want);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_W'({idx, 2'b00});
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         errors++;
         if (errors <= 10)
            $display("register %0d readback: expected %h got %h", idx, want, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_config(logic [WORD_W-1:0] tthr, logic [WORD_W-1:0] rthr,
                             logic [WORD_W-1:0] seed);
      write_reg(REG_TABLE_THR, tthr);
      write_reg(REG_ROUTE_THR, rthr);
      write_reg(REG_SEED, seed);
      check_reg(REG_TABLE_THR, table_thr);
      check_reg(REG_ROUTE_THR, route_thr);
      check_reg(REG_SEED, seed_val);
   endtask

   // Wait until every result has come and the block has settled
   task automatic drain();
      while (pending_genes.size() != 0 || push || expected_genes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic cgm_req_type make_gene(logic kind, logic [NODE_W-1:0] node,
                                             logic [TABLE_W-1:0] tt,
                                             logic [ROUTE_W-1:0] rw,
                                             logic [OMAP_W-1:0] om);
      cgm_req_type g;
      g.item_kind    = kind;
      g.node_index   = node;
      g.truth_table  = tt;
      g.routing_word = rw;
      g.output_map   = om;
      return g;
   endfunction

   function automatic cgm_req_type random_gene();
      cgm_req_type g;
      g.item_kind = ($urandom_range(0, 99) < 60) ? KIND_NODE : KIND_OUT;
      if ($urandom_range(0, 9) == 0)
         g.node_index = NODE_W'($urandom_range(NODES, 31));
      else
         g.node_index = NODE_W'($urandom_range(0, NODES - 1));
      g.truth_table  = TABLE_W'($urandom());
      g.routing_word = ROUTE_W'($urandom());
      g.output_map   = OMAP_W'($urandom());
      return g;
   endfunction

   // Field extremes, both kinds, index clamp cases and passed-through fields
   task automatic queue_directed();
      pending_genes.push_back(make_gene(KIND_NODE, 0, '0, '0, '0));
      pending_genes.push_back(make_gene(KIND_NODE, 0, '1, '1, '1));
      pending_genes.push_back(make_gene(KIND_NODE, NODE_W'(NODES - 1), '1, '0, '1));
      pending_genes.push_back(make_gene(KIND_NODE, NODE_W'(NODES), '0, '1, '0));
      pending_genes.push_back(make_gene(KIND_NODE, '1, 16'hA5A5, 20'h5A5A5, 18'h2AAAA));
      pending_genes.push_back(make_gene(KIND_OUT, 0, '0, '0, '0));
      pending_genes.push_back(make_gene(KIND_OUT, '1, '1, '1, '1));
      pending_genes.push_back(make_gene(KIND_OUT, 5'd7, 16'h1234, 20'hFEDCB, 18'h15555));
      pending_genes.push_back(make_gene(KIND_NODE, 5'd1, 16'h00FF, 20'h0041F, 18'h3F03F));
      pending_genes.push_back(make_gene(KIND_OUT, 5'd15, 16'hFF00, 20'hF83E0, 18'h00FC0));
      pending_genes.push_back(make_gene(KIND_NODE, 5'd15, 16'h8001, 20'h84210, 18'h20820));
      pending_genes.push_back(make_gene(KIND_OUT, 5'd30, 16'h7FFE, 20'h7BDEF, 18'h1F7DF));
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++)
         pending_genes.push_back(random_gene());
   endtask

   // Test sequence
   initial begin
      table_thr = TABLE_THR_RESET;
      route_thr = ROUTE_THR_RESET;
      seed_val  = SEED_RESET;
      gen_word  = SEED_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values, then directed words at the reset setting
      check_reg(REG_TABLE_THR, table_thr);
      check_reg(REG_ROUTE_THR, route_thr);
      check_reg(REG_SEED, seed_val);
      queue_directed();
      drain();

      // Every test hits: each field is redrawn, some to their old values
      set_config('1, '1, $urandom() | 32'd1);
      queue_directed();
      drain();

      // Random phases across several settings
      set_config(TABLE_THR_RESET, ROUTE_THR_RESET, $urandom() | 32'd1);
      queue_random(230);
      drain();
      set_config('1, '1, 32'd1);
      queue_random(230);
      drain();
      set_config('0, '0, $urandom() | 32'd1);
      queue_random(200);
      drain();
      set_config($urandom(), $urandom(), $urandom() | 32'd1);
      queue_random(230);
      drain();
      set_config(32'h8000_0000, 32'h8000_0000, '1);
      queue_random(230);
      drain();
      set_config('1, '0, $urandom() | 32'd1);
      queue_random(200);
      drain();
      set_config('0, '1, $urandom() | 32'd1);
      queue_random(200);
      drain();
      set_config(32'h4000_0000, 32'h2000_0000, $urandom() | 32'd1);
      queue_random(250);
      drain();

      // Zero seed: the generator sticks at zero
      set_config(32'h0000_0001, 32'h0000_0001, '0);
      queue_random(40);
      drain();

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/cgm_pkg.sv
hdl/cgm_front.sv
hdl/cgm_back.sv
hdl/cgp_genome_mutator_top.sv
hdl/cgm_checker.sv
bench/tb_top.sv
